### hdl/tsbc_pkg.sv
// Shared types and constants for the byte two-square cipher core.
// No dependencies; used by every module in hdl/ except tsbc_ram.
`timescale 1ns / 1ps
`default_nettype none
package tsbc_pkg;

  localparam int SQUARE_SIDE = 16;
  localparam int CELLS       = SQUARE_SIDE * SQUARE_SIDE;
  localparam int CELL_W      = $clog2(CELLS);
  localparam int SIDE_W      = $clog2(SQUARE_SIDE);
  localparam int BYTE_W      = 8;
  localparam int KEY_BYTES   = 32;
  localparam int KEY_BYTE_W  = $clog2(KEY_BYTES);
  localparam int KEY_WORDS   = 4;
  localparam int KEY_WORD_W  = 64;
  localparam int CFG_IDX_W   = $clog2(KEY_WORDS);

  typedef enum logic {
    OP_ENCRYPT = 1'b0,
    OP_DECRYPT = 1'b1
  } op_t;

  typedef enum logic {
    STATUS_OK          = 1'b0,
    STATUS_LONE_DECRYPT = 1'b1
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_KEY,
    ST_FILL,
    ST_IDLE,
    ST_LOOK,
    ST_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic build_clear;
    logic key_step;
    logic fill_step;
    logic accept;
    logic look;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic key_last;
    logic fill_last;
    logic key_changed;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

### hdl/tsbc_ram.sv
// Generic RAM: one write port, two registered read ports.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module tsbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule
`default_nettype wire

### hdl/tsbc_ctrl.sv
// Controller: sequences the table build and the per-pair lookups.
// Depends on tsbc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tsbc_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire tsbc_pkg::dp_status_t status,
  output tsbc_pkg::dp_cmd_t         cmd
);

  tsbc_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tsbc_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      tsbc_pkg::ST_CLEAR: begin
        cmd.build_clear = 1'b1;
        state_nxt       = tsbc_pkg::ST_KEY;
      end
      tsbc_pkg::ST_KEY: begin
        cmd.key_step = 1'b1;
        if (status.key_last) begin
          state_nxt = tsbc_pkg::ST_FILL;
        end
      end
      tsbc_pkg::ST_FILL: begin
        cmd.fill_step = 1'b1;
        if (status.fill_last) begin
          state_nxt = tsbc_pkg::ST_IDLE;
        end
      end
      tsbc_pkg::ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
        if (in_tvalid) begin
          state_nxt = tsbc_pkg::ST_LOOK;
        end
      end
      tsbc_pkg::ST_LOOK: begin
        cmd.look  = 1'b1;
        state_nxt = tsbc_pkg::ST_OUT;
      end
      tsbc_pkg::ST_OUT: begin
        cmd.load_out = status.out_free;
        if (status.out_free) begin
          state_nxt = tsbc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tsbc_pkg::ST_CLEAR;
      end
    endcase
    // rebuild after any key write
    if (status.key_changed) begin
      state_nxt = tsbc_pkg::ST_CLEAR;
    end
  end

endmodule
`default_nettype wire

### hdl/tsbc_datapath.sv
// Datapath: key registers, seen map, square and position RAMs, output register.
// Depends on tsbc_pkg and tsbc_ram.
`timescale 1ns / 1ps
`default_nettype none
module tsbc_datapath (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_wr_en,
  input  wire logic [tsbc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [tsbc_pkg::KEY_WORD_W-1:0]    cfg_wdata,
  input  wire logic [2*tsbc_pkg::BYTE_W-1:0]      in_tdata,
  input  wire logic [1:0]                         in_tuser,
  output logic      [2*tsbc_pkg::BYTE_W-1:0]      out_tdata,
  output logic                                    out_tuser,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  input  wire tsbc_pkg::dp_cmd_t                  cmd,
  output tsbc_pkg::dp_status_t                    status
);

  localparam int BW = tsbc_pkg::BYTE_W;
  localparam int CW = tsbc_pkg::CELL_W;
  localparam int SW = tsbc_pkg::SIDE_W;

  logic [tsbc_pkg::KEY_WORD_W-1:0] key_r [tsbc_pkg::KEY_WORDS];
  logic [tsbc_pkg::KEY_WORDS*tsbc_pkg::KEY_WORD_W-1:0] key_flat;
  logic [tsbc_pkg::CELLS-1:0] seen_r;
  logic [CW-1:0]              idx_r;
  logic [CW-1:0]              fill_r;
  logic [BW-1:0]              cand;
  logic                       step;
  logic                       wr_en;
  logic                       op_r;
  logic                       lone_r;
  logic                       err;
  logic [BW-1:0]              byte_a;
  logic [BW-1:0]              byte_b;
  logic [CW-1:0]              pos_a;
  logic [CW-1:0]              pos_b;
  logic [CW-1:0]              sq_addr_a;
  logic [CW-1:0]              sq_addr_b;
  logic [BW-1:0]              sq_a;
  logic [BW-1:0]              sq_b;
  logic [BW-1:0]              sq_rd_a;
  logic [BW-1:0]              sq_rd_b;
  logic [BW-1:0]              first_out_r;
  logic [BW-1:0]              second_out_r;
  logic                       status_r;
  logic                       out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < tsbc_pkg::KEY_WORDS; i++) begin
        key_r[i] <= '0;
      end
    end else if (cfg_wr_en) begin
      key_r[cfg_index] <= cfg_wdata;
    end
  end

  always_comb begin
    for (int i = 0; i < tsbc_pkg::KEY_WORDS; i++) begin
      key_flat[i*tsbc_pkg::KEY_WORD_W +: tsbc_pkg::KEY_WORD_W] = key_r[i];
    end
  end

  // build: key bytes first, then every byte value in ascending order
  assign step  = cmd.key_step | cmd.fill_step;
  assign cand  = cmd.key_step ? key_flat[{idx_r[tsbc_pkg::KEY_BYTE_W-1:0], 3'b000} +: BW]
                              : BW'(idx_r);
  assign wr_en = step & ~seen_r[cand];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
      idx_r  <= '0;
      fill_r <= '0;
    end else if (cmd.build_clear) begin
      seen_r <= '0;
      idx_r  <= '0;
      fill_r <= '0;
    end else if (step) begin
      idx_r <= cmd.key_step && idx_r[tsbc_pkg::KEY_BYTE_W-1:0] == '1 ? '0 : idx_r + 1'b1;
      if (wr_en) begin
        seen_r[cand] <= 1'b1;
        fill_r       <= fill_r + 1'b1;
      end
    end
  end

  assign status.key_last    = idx_r[tsbc_pkg::KEY_BYTE_W-1:0] == '1;
  assign status.fill_last   = idx_r == '1;
  assign status.key_changed = cfg_wr_en;
  assign status.out_free    = ~out_valid_r | out_tready;

  // per-pair lookup
  assign byte_a = in_tdata[BW-1:0];
  assign byte_b = in_tuser[1] ? in_tdata[BW-1:0] : in_tdata[2*BW-1:BW];

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r   <= in_tuser[0];
      lone_r <= in_tuser[1];
    end
  end

  tsbc_ram #(
    .WIDTH (BW),
    .DEPTH (tsbc_pkg::CELLS)
  ) u_pos_ram (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (CW'(cand)),
    .wdata   (BW'(fill_r)),
    .re      (cmd.accept),
    .raddr_a (CW'(byte_a)),
    .raddr_b (CW'(byte_b)),
    .rdata_a (pos_a),
    .rdata_b (pos_b)
  );

  assign sq_addr_a = {pos_a[CW-1:SW], pos_b[SW-1:0]};
  assign sq_addr_b = {pos_b[CW-1:SW], pos_a[SW-1:0]};

  tsbc_ram #(
    .WIDTH (BW),
    .DEPTH (tsbc_pkg::CELLS)
  ) u_sq_ram (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (fill_r),
    .wdata   (cand),
    .re      (cmd.look),
    .raddr_a (sq_addr_a),
    .raddr_b (sq_addr_b),
    .rdata_a (sq_rd_a),
    .rdata_b (sq_rd_b)
  );

  assign err  = lone_r & (op_r == tsbc_pkg::OP_DECRYPT);
  assign sq_a = err ? '0 : sq_rd_a;
  assign sq_b = err ? '0 : sq_rd_b;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      first_out_r  <= sq_a;
      second_out_r <= sq_b;
      status_r     <= err ? tsbc_pkg::STATUS_LONE_DECRYPT : tsbc_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tdata  = {second_out_r, first_out_r};
  assign out_tuser  = status_r;
  assign out_tvalid = out_valid_r;

endmodule
`default_nettype wire

### hdl/two_square_byte_cipher_core.sv
// Top level of the byte two-square cipher core.
// Depends on tsbc_pkg, tsbc_ctrl, tsbc_datapath and tsbc_ram.
//
// Channel  | Direction | Payload
// in_      | slave     | tdata: first_byte[7:0], second_byte[15:8]
//          |           | tuser: operation[0], lone_byte[1]
// out_     | master    | tdata: first_out[7:0], second_out[15:8]; tuser: status[0]
// cfg_     | write     | cfg_index selects key_word_0..3, cfg_wdata 64 bits
//
// After reset and after every key write the square and position tables are
// rebuilt (one clear, then the 32 key bytes, then all 256 byte values); in_tready
// stays low meanwhile. A pair's result passes through two dependent registered
// reads (position RAM, then square RAM) and then the output register.
// One pair is in flight at a time; the next is taken once its result is in
// the output register, which holds under out_tready low.
`timescale 1ns / 1ps
`default_nettype none
module two_square_byte_cipher_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_wr_en,
  input  wire logic [tsbc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tsbc_pkg::KEY_WORD_W-1:0] cfg_wdata,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [15:0]                     in_tdata,  // first_byte, second_byte
  input  wire logic [1:0]                      in_tuser,  // operation, lone_byte
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic      [15:0]                     out_tdata, // first_out, second_out
  output logic                                 out_tuser  // status
);

  tsbc_pkg::dp_cmd_t    cmd;
  tsbc_pkg::dp_status_t status;

  tsbc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  tsbc_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .status     (status)
  );

endmodule
`default_nettype wire

### hdl/tsbc_checker.sv
// Port-level checks for the byte two-square cipher core, bound to the top level.
// Depends on two_square_byte_cipher_core and tsbc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tsbc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        cfg_wr_en,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata,
  input wire logic        out_tuser
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == tsbc_pkg::STATUS_LONE_DECRYPT |-> out_tdata == '0)
    else $error("error result carries nonzero bytes");

  a_reset_build: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !in_tready)
    else $error("input taken before tables are built");

  a_key_rebuild: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> !in_tready)
    else $error("input taken right after key write");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second transfer while a pair is in flight");

endmodule

bind two_square_byte_cipher_core tsbc_checker u_tsbc_checker (.*);
`default_nettype wire
